>>> rtl/hvs_pkg.sv
// ----------------------------------------------------------------------------
// hvs_pkg
// Shared types and constants of the haptic vibration synthesizer.
// ----------------------------------------------------------------------------
`default_nettype none

package hvs_pkg;

  localparam int TABLE_SIZE      = 1024;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int STEP_W  = 26;
  localparam int ALPHA_W = 16;
  localparam int TICK_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABS_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_STEP_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_STEP_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_ALPHA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_ALPHA  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_ON      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_CYCLE   = 3'd7;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] ROAD_SNAP  = 32'd429497;
  localparam logic [31:0] SLIP_SNAP  = 32'd26844;
  localparam logic signed [31:0] SLIP_LO = 32'sd80530637;
  localparam logic signed [31:0] SLIP_HI = 32'sd402653184;
  localparam logic [15:0] ABS_OFF    = 16'd164;
  localparam logic [31:0] RANDOM_SEED = 32'd67691;

  typedef struct packed {
    logic [STEP_W-1:0]  abs_step;
    logic [STEP_W-1:0]  road_step;
    logic [STEP_W-1:0]  slip_step_a;
    logic [STEP_W-1:0]  slip_step_b;
    logic [ALPHA_W-1:0] rise_alpha;
    logic [ALPHA_W-1:0] fall_alpha;
    logic [TICK_W-1:0]  abs_on_ticks;
    logic [TICK_W-1:0]  abs_cycle_ticks;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       diff;
    logic       mul;
    logic       smooth;
    logic       amp;
    logic       taddr;
    logic       tmul;
    logic       tacc;
    logic [1:0] tsel;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hvs_cfg.sv
// ----------------------------------------------------------------------------
// hvs_cfg
// Configuration register file, written through its own request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hvs_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [hvs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [hvs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output hvs_pkg::cfg_t                           cfg_o
);

  hvs_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.abs_step        <= 26'd251658;
      cfg_q.road_step       <= 26'd419430;
      cfg_q.slip_step_a     <= 26'd209715;
      cfg_q.slip_step_b     <= 26'd209715;
      cfg_q.rise_alpha      <= 16'd741;
      cfg_q.fall_alpha      <= 16'd249;
      cfg_q.abs_on_ticks    <= 11'd800;
      cfg_q.abs_cycle_ticks <= 11'd1333;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hvs_pkg::REG_ABS_STEP:    cfg_q.abs_step        <= cfg_data_i;
        hvs_pkg::REG_ROAD_STEP:   cfg_q.road_step       <= cfg_data_i;
        hvs_pkg::REG_SLIP_STEP_A: cfg_q.slip_step_a     <= cfg_data_i;
        hvs_pkg::REG_SLIP_STEP_B: cfg_q.slip_step_b     <= cfg_data_i;
        hvs_pkg::REG_RISE_ALPHA:  cfg_q.rise_alpha      <= cfg_data_i[15:0];
        hvs_pkg::REG_FALL_ALPHA:  cfg_q.fall_alpha      <= cfg_data_i[15:0];
        hvs_pkg::REG_ABS_ON:      cfg_q.abs_on_ticks    <= cfg_data_i[10:0];
        hvs_pkg::REG_ABS_CYCLE:   cfg_q.abs_cycle_ticks <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/hvs_ctrl.sv
// ----------------------------------------------------------------------------
// hvs_ctrl
// Sequencer: walks one sample through smoothing, amplitudes, three tone
// multiply-accumulates and the final state update.
// ----------------------------------------------------------------------------
`default_nettype none

module hvs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  hvs_pkg::status_t     status_i,
  output hvs_pkg::cmd_t        cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIFF   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_SMOOTH = 4'd3;
  localparam logic [3:0] ST_AMP    = 4'd4;
  localparam logic [3:0] ST_TADDR  = 4'd5;
  localparam logic [3:0] ST_TMUL   = 4'd6;
  localparam logic [3:0] ST_TACC   = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] tsel_q, tsel_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    tsel_d  = tsel_q;
    cmd_o   = '0;
    cmd_o.tsel = tsel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = ST_AMP;
      end
      ST_AMP: begin
        cmd_o.amp = 1'b1;
        tsel_d    = 2'd0;
        state_d   = ST_TADDR;
      end
      ST_TADDR: begin
        cmd_o.taddr = 1'b1;
        state_d     = ST_TMUL;
      end
      ST_TMUL: begin
        cmd_o.tmul = 1'b1;
        state_d    = ST_TACC;
      end
      ST_TACC: begin
        cmd_o.tacc = 1'b1;
        if (tsel_q == 2'd2) begin
          state_d = ST_FIN;
        end else begin
          tsel_d  = tsel_q + 2'd1;
          state_d = ST_TADDR;
        end
      end
      ST_FIN: begin
        // hold here while the previous sample is still unread
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tsel_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      tsel_q  <= tsel_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hvs_datapath.sv
// ----------------------------------------------------------------------------
// hvs_datapath
// Smoothers, tone amplitudes, sine ROM, accumulator, phase and swap state,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvs_datapath #(
  parameter int TableSize     = hvs_pkg::TABLE_SIZE,
  parameter int PhaseFracBits = hvs_pkg::PHASE_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  hvs_pkg::cfg_t           cfg_i,
  input  hvs_pkg::cmd_t           cmd_i,
  output hvs_pkg::status_t        status_o,
  input  wire logic [15:0]        abs_level_i,
  input  wire logic [15:0]        susp_delta_i,
  input  wire logic signed [15:0] slip_level_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              dac_code_o
);

  // TableSize is taken as a power of two
  localparam int IdxW = $clog2(TableSize);
  localparam int PhW  = IdxW + PhaseFracBits;
  localparam int SumW = ((PhW > hvs_pkg::STEP_W) ? PhW : hvs_pkg::STEP_W) + 1;
  localparam longint unsigned N = longint'(TableSize);

  // ---------------- sine ROM contents, Q1.15 ----------------
  logic signed [15:0] sine_rom [TableSize];

  for (genvar gi = 0; gi < TableSize; gi++) begin : g_rom
    localparam longint unsigned A0  = 4 * longint'(gi);
    localparam bit              NEG = (A0 >= 2 * N);
    localparam longint unsigned A1  = NEG ? A0 - 2 * N : A0;
    localparam longint unsigned A2  = (A1 > N) ? 2 * N - A1 : A1;
    localparam longint unsigned X   = A2 * hvs_pkg::HALF_PI_Q30 / N;
    localparam longint unsigned X2  = (X * X) >> 30;
    localparam longint unsigned T1  = ((X  * X2) >> 30) / 6;
    localparam longint unsigned T2  = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3  = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4  = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5  = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6  = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned SUM = X - T1 + T2 - T3 + T4 - T5 + T6;
    localparam longint unsigned R0  = (SUM + 16384) >> 15;
    localparam longint unsigned R1  = (R0 > 32767) ? 32767 : R0;
    localparam logic [15:0]     RV  = 16'(R1);
    assign sine_rom[gi] = NEG ? -$signed(RV) : $signed(RV);
  end

  // ---------------- state ----------------
  logic [15:0]        level_q, susp_q;
  logic signed [15:0] slip_q;
  logic [31:0]        road_q;
  logic signed [31:0] slips_q;
  logic [hvs_pkg::TICK_W-1:0] gate_q;
  logic [PhW-1:0]     abs_ph_q, road_ph_q, slip_ph_q;
  logic               toggle_q;
  logic [9:0]         swap_q;
  logic [31:0]        rnd_q;

  logic signed [32:0] rdiff_q, sdiff_q;
  logic [15:0]        ralpha_q;
  logic [31:0]        rmove_q, smove_q;
  logic               rsnap_q, ssnap_q;
  logic [23:0]        abs_amp_q, road_amp_q, slip_amp_q;
  logic               slip_on_q;
  logic signed [15:0] rom_q;
  logic signed [40:0] prod_q;
  logic signed [41:0] acc_q;
  logic               out_valid_q;
  logic [7:0]         code_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign dac_code_o  = code_q;

  // ---------------- smoothing ----------------
  logic [31:0]        rtarget;
  logic signed [31:0] starget;
  logic [32:0]        rmag, smag;
  logic [48:0]        rprod, sprod;
  logic [31:0]        road_d;
  logic signed [31:0] slips_d;

  assign rtarget = {susp_q, 16'h0000};
  assign starget = {slip_q, 16'h0000};
  assign rmag  = rdiff_q[32] ? 33'(-rdiff_q) : 33'(rdiff_q);
  assign smag  = sdiff_q[32] ? 33'(-sdiff_q) : 33'(sdiff_q);
  assign rprod = ralpha_q * rmag;
  assign sprod = cfg_i.rise_alpha * smag;

  always_comb begin
    if (rsnap_q)         road_d = rtarget;
    else if (rdiff_q[32]) road_d = road_q - rmove_q;
    else                 road_d = road_q + rmove_q;
    if (ssnap_q)         slips_d = starget;
    else if (sdiff_q[32]) slips_d = slips_q - $signed(smove_q);
    else                 slips_d = slips_q + $signed(smove_q);
  end

  // ---------------- amplitudes ----------------
  logic [23:0]        abs_amp_d, road_amp_d, slip_amp_d;
  logic [40:0]        road_x500;
  logic signed [35:0] s10;
  logic signed [39:0] s90;
  logic               slip_on_d;

  assign slip_on_d = (slips_q >= hvs_pkg::SLIP_LO);
  assign road_x500 = road_q * 9'd500;
  assign s10 = 36'(slips_q) * 36'sd10 - 36'sd805306368;
  assign s90 = 40'(s10) * 40'sd9;

  always_comb begin
    abs_amp_d = (gate_q <= cfg_i.abs_on_ticks) ? 24'(level_q) * 24'd240 : 24'd0;
    if (road_x500[40:16] > 25'(30 << 16)) road_amp_d = 24'(30 << 16);
    else                                  road_amp_d = road_x500[39:16];
    if (!slip_on_d)                       slip_amp_d = 24'd0;
    else if (slips_q > hvs_pkg::SLIP_HI)  slip_amp_d = 24'(37 << 16);
    else slip_amp_d = 24'(10 << 16) + 24'(s90 >>> 14);
  end

  // ---------------- tone select ----------------
  logic [23:0]     amp_sel;
  logic [IdxW-1:0] idx_sel;

  always_comb begin
    case (cmd_i.tsel)
      2'd0: begin
        amp_sel = abs_amp_q;
        idx_sel = abs_ph_q[PhW-1:PhaseFracBits];
      end
      2'd1: begin
        amp_sel = road_amp_q;
        idx_sel = road_ph_q[PhW-1:PhaseFracBits];
      end
      default: begin
        amp_sel = slip_amp_q;
        idx_sel = slip_ph_q[PhW-1:PhaseFracBits];
      end
    endcase
  end

  // ---------------- end of sample ----------------
  logic [7:0]  code_d;
  logic [hvs_pkg::TICK_W:0] gate_inc;
  logic [hvs_pkg::TICK_W-1:0] gate_d;
  logic [31:0] rnd_n;
  logic [9:0]  swap_inc, swap_lim;
  logic        swap_hit;
  logic        toggle_n;

  always_comb begin
    if (acc_q <= 42'sd0)            code_d = 8'd0;
    else if (acc_q[41:31] > 11'd255) code_d = 8'd255;
    else                            code_d = acc_q[38:31];
  end

  always_comb begin
    gate_inc = {1'b0, gate_q} + 12'd1;
    if (gate_inc > {1'b0, cfg_i.abs_cycle_ticks}) begin
      gate_inc = gate_inc - {1'b0, cfg_i.abs_cycle_ticks};
    end
    gate_d = gate_inc[hvs_pkg::TICK_W-1:0];
  end

  assign rnd_n    = hvs_pkg::xorshift32(rnd_q);
  assign swap_inc = swap_q + 10'd1;
  assign swap_lim = 10'd512 + {2'b00, rnd_n[9:2]};
  assign swap_hit = (swap_inc >= swap_lim);
  assign toggle_n = swap_hit ? !toggle_q : toggle_q;

  function automatic logic [PhW-1:0] advance(input logic [PhW-1:0] ph,
                                             input logic [hvs_pkg::STEP_W-1:0] st);
    logic [SumW-1:0] s;
    s = SumW'(ph) + SumW'(st);
    return s[PhW-1:0];
  endfunction

  // ---------------- registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      level_q <= abs_level_i;
      susp_q  <= susp_delta_i;
      slip_q  <= slip_level_i;
    end
    if (cmd_i.diff) begin
      rdiff_q  <= $signed({1'b0, rtarget}) - $signed({1'b0, road_q});
      sdiff_q  <= 33'(starget) - 33'(slips_q);
      ralpha_q <= (rtarget > road_q) ? cfg_i.rise_alpha : cfg_i.fall_alpha;
    end
    if (cmd_i.mul) begin
      rmove_q <= rprod[47:16];
      smove_q <= sprod[47:16];
      rsnap_q <= (rmag < 33'(hvs_pkg::ROAD_SNAP));
      ssnap_q <= (smag < 33'(hvs_pkg::SLIP_SNAP));
    end
    if (cmd_i.amp) begin
      abs_amp_q  <= abs_amp_d;
      road_amp_q <= road_amp_d;
      slip_amp_q <= slip_amp_d;
      slip_on_q  <= slip_on_d;
    end
    if (cmd_i.taddr) rom_q  <= sine_rom[idx_sel];
    if (cmd_i.tmul)  prod_q <= $signed({1'b0, amp_sel}) * rom_q;
    if (cmd_i.finish) code_q <= code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      road_q      <= '0;
      slips_q     <= '0;
      gate_q      <= '0;
      abs_ph_q    <= '0;
      road_ph_q   <= '0;
      slip_ph_q   <= '0;
      toggle_q    <= 1'b1;
      swap_q      <= '0;
      rnd_q       <= hvs_pkg::RANDOM_SEED;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.smooth) begin
        road_q  <= road_d;
        slips_q <= slips_d;
      end
      if (cmd_i.amp)  acc_q <= 42'sd128 <<< 31;
      if (cmd_i.tacc) acc_q <= acc_q + 42'(prod_q);
      if (cmd_i.finish) begin
        if (level_q < hvs_pkg::ABS_OFF) begin
          gate_q   <= '0;
          abs_ph_q <= '0;
        end else begin
          gate_q   <= gate_d;
          abs_ph_q <= advance(abs_ph_q, cfg_i.abs_step);
        end
        road_ph_q <= advance(road_ph_q, cfg_i.road_step);
        if (!slip_on_q) begin
          slip_ph_q <= '0;
        end else begin
          rnd_q     <= rnd_n;
          swap_q    <= swap_hit ? 10'd0 : swap_inc;
          toggle_q  <= toggle_n;
          slip_ph_q <= advance(slip_ph_q,
                               toggle_n ? cfg_i.slip_step_a : cfg_i.slip_step_b);
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/haptic_vibration_synth.sv
// ----------------------------------------------------------------------------
// haptic_vibration_synth
// Three-tone vibration synthesizer producing one motor drive sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick request: ABS level, suspension delta and slip.
//   m_axis returns one 8-bit drive code per request, 128 is rest.
//   cfg port writes the eight tuning registers; write only while idle.
// The sequencer takes one request at a time: the next is accepted only
//   once it has finished the last one. It walks one shared sine ROM port
//   and one tone multiplier through the three tones, after three
//   smoothing steps and an amplitude step.
// The output sits in a register: the next request is accepted while a code
//   waits, and the sequencer holds in its last step when the receiver
//   stalls with a code still unread.
// Reset clears all smoothers, phases and counters, reloads the register
//   defaults and the noise seed; no warm-up is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_vibration_synth #(
  parameter int TableSize     = hvs_pkg::TABLE_SIZE,
  parameter int PhaseFracBits = hvs_pkg::PHASE_FRAC_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] abs_level, [31:16] susp_delta, [47:32] slip_level
  input  wire logic [47:0]                    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [7:0] dac_code
  output logic [7:0]                          m_axis_tdata_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hvs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  hvs_pkg::cfg_t    cfg;
  hvs_pkg::cmd_t    cmd;
  hvs_pkg::status_t status;

  hvs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hvs_datapath #(
    .TableSize     (TableSize),
    .PhaseFracBits (PhaseFracBits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .abs_level_i  (s_axis_tdata_i[15:0]),
    .susp_delta_i (s_axis_tdata_i[31:16]),
    .slip_level_i (s_axis_tdata_i[47:32]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .dac_code_o   (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

>>> rtl/hvs_checker.sv
// ----------------------------------------------------------------------------
// hvs_checker
// Port-level checks of the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hvs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid_i,
  input wire logic s_axis_tready_o,
  input wire logic m_axis_tvalid_o,
  input wire logic m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  a_rst_no_out: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o) else $error("output valid during reset");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o) else $error("request taken while busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid_o)) else $error("result too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output changed");

endmodule

bind haptic_vibration_synth hvs_checker u_hvs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
